// ===== rtl/lasp_pkg.sv =====
// lasp_pkg: shared types and codes for the led animation stream parser
// no dependencies; used by lasp_parse, led_animation_stream_parser_top and lasp_result_check
`default_nettype none

package lasp_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_PIXEL  = 2'd2;

	// parse phases (code 3 is handled as header)
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_RECORD = 2'd1;
	localparam logic [1:0] PH_PIXEL  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  mode;
		logic [7:0]  fps;
		logic [15:0] frame_total;
		logic [15:0] pixel_count;
		logic [16:0] hold_frames;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/led_animation_stream_parser_top.sv =====
// led_animation_stream_parser_top: byte stream in, header/frame/pixel results out
// depends on lasp_pkg and lasp_parse
//
// channel | direction | handshake          | payload
// in      | input     | in_valid, in_stall  | stream_byte
// out     | output    | out_valid, out_stall| kind, mode, fps, frame_total, pixel_count,
//         |           |                    | hold_frames, pos_x, pos_y, red, green, blue
//
// one byte is taken every cycle while in_stall is low; a result is registered before it shows
// the parse state advances in one step per byte, between the input and the output register
// an output register plus one skid entry hold results; in_stall rises only when the skid is full
// reset clears the parse state and empties both result slots; the first byte is read as a header
`default_nettype none

module led_animation_stream_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  stream_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       mode,
	output logic [7:0]       fps,
	output logic [15:0]      frame_total,
	output logic [15:0]      pixel_count,
	output logic [16:0]      hold_frames,
	output logic [7:0]       pos_x,
	output logic [7:0]       pos_y,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	logic              take;
	logic              out_take;
	logic              res_valid;
	lasp_pkg::result_t res;
	lasp_pkg::result_t out_q;
	lasp_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              out_free;

	assign in_stall = skid_valid_q;
	assign take     = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = out_take || !out_valid_q;

	lasp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (stream_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take && res_valid;
			end
		end else if (take && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload slots, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take && res_valid) begin
				out_q <= res;
			end
		end else if (take && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign mode        = out_q.mode;
	assign fps         = out_q.fps;
	assign frame_total = out_q.frame_total;
	assign pixel_count = out_q.pixel_count;
	assign hold_frames = out_q.hold_frames;
	assign pos_x       = out_q.pos_x;
	assign pos_y       = out_q.pos_y;
	assign red         = out_q.red;
	assign green       = out_q.green;
	assign blue        = out_q.blue;

	// skid entry is only ever filled behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a result produced while the output is blocked lands in the skid
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_valid && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("result lost while output stalled");

	// a result that reaches an empty output shows the next cycle
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_valid) |=> out_valid_q)
		else $error("result did not reach the output register");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.kind == lasp_pkg::KIND_HEADER ||
			out_q.kind == lasp_pkg::KIND_FRAME || out_q.kind == lasp_pkg::KIND_PIXEL))
		else $error("output beat carries an unknown kind");

endmodule

`default_nettype wire

// ===== rtl/lasp_parse.sv =====
// lasp_parse: byte-wise parse state and the result built from each accepted beat
// depends on lasp_pkg
`default_nettype none

module lasp_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       stream_byte,
	output logic                  res_valid,
	output lasp_pkg::result_t     res
);

	logic [1:0]  phase_q, phase_d;
	logic [2:0]  pos_q, pos_d;
	logic [31:0] held_q, held_d;
	logic [15:0] total_q, total_d;
	logic [15:0] left_q, left_d;
	logic [16:0] shown_q, shown_d;

	logic [15:0] rep;
	logic [16:0] hold;
	logic [31:0] held_gather;

	assign rep  = {stream_byte, held_q[23:16]};
	assign hold = (rep == 16'd0) ? 17'h10000 : {1'b0, rep};

	always_comb begin
		held_gather = held_q;
		held_gather[{pos_q[1:0], 3'b000} +: 8] = stream_byte;
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		held_d    = held_q;
		total_d   = total_q;
		left_d    = left_q;
		shown_d   = shown_q;
		res       = '0;
		res_valid = 1'b0;
		case (phase_q)
			lasp_pkg::PH_RECORD: begin
				if (pos_q < 3'd3) begin
					held_d = held_gather;
					pos_d  = pos_q + 3'd1;
				end else begin
					res_valid       = 1'b1;
					res.kind        = lasp_pkg::KIND_FRAME;
					res.pixel_count = held_q[15:0];
					res.hold_frames = hold;
					shown_d         = shown_q + hold;
					pos_d           = 3'd0;
					held_d          = '0;
					left_d          = held_q[15:0];
					if (held_q[15:0] != 16'd0) begin
						phase_d = lasp_pkg::PH_PIXEL;
					end else if (shown_d >= {1'b0, total_q}) begin
						phase_d = lasp_pkg::PH_HEADER;
					end else begin
						phase_d = lasp_pkg::PH_RECORD;
					end
				end
			end
			lasp_pkg::PH_PIXEL: begin
				if (pos_q < 3'd4) begin
					held_d = held_gather;
					pos_d  = pos_q + 3'd1;
				end else begin
					res_valid = 1'b1;
					res.kind  = lasp_pkg::KIND_PIXEL;
					res.pos_x = held_q[7:0];
					res.pos_y = held_q[15:8];
					res.red   = held_q[23:16];
					res.green = held_q[31:24];
					res.blue  = stream_byte;
					left_d    = left_q - 16'd1;
					pos_d     = 3'd0;
					held_d    = '0;
					// last pixel of the record closes it
					if (left_d == 16'd0) begin
						if (shown_q >= {1'b0, total_q}) begin
							phase_d = lasp_pkg::PH_HEADER;
						end else begin
							phase_d = lasp_pkg::PH_RECORD;
						end
					end
				end
			end
			default: begin
				if (pos_q < 3'd3) begin
					phase_d = lasp_pkg::PH_HEADER;
					held_d  = held_gather;
					pos_d   = pos_q + 3'd1;
				end else begin
					total_d         = rep;
					shown_d         = '0;
					left_d          = '0;
					res_valid       = 1'b1;
					res.kind        = lasp_pkg::KIND_HEADER;
					res.mode        = held_q[7:0];
					res.fps         = held_q[15:8];
					res.frame_total = rep;
					pos_d           = 3'd0;
					held_d          = '0;
					// zero frame total means the loop is already done
					phase_d = (rep == 16'd0) ? lasp_pkg::PH_HEADER : lasp_pkg::PH_RECORD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lasp_pkg::PH_HEADER;
			pos_q   <= '0;
			held_q  <= '0;
			total_q <= '0;
			left_q  <= '0;
			shown_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			held_q  <= held_d;
			total_q <= total_d;
			left_q  <= left_d;
			shown_q <= shown_d;
		end
	end

endmodule

`default_nettype wire

// ===== verif/lasp_result_check.sv =====
`timescale 1ns / 1ps
// lasp_result_check: watches the byte and result channels of the stream parser, tracks the
// parse state itself and compares every result beat with the oldest one it predicted
// depends on lasp_pkg
module lasp_result_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  stream_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  mode,
	input  logic [7:0]  fps,
	input  logic [15:0] frame_total,
	input  logic [15:0] pixel_count,
	input  logic [16:0] hold_frames,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output int          outstanding,
	output int          fail_count
);

	logic [1:0]        phase = lasp_pkg::PH_HEADER;
	logic [2:0]        byte_idx = '0;
	logic [31:0]       gathered = '0;
	logic [15:0]       loop_total = '0;
	logic [15:0]       pixels_left = '0;
	logic [16:0]       shown = '0;
	lasp_pkg::result_t due_results[$];
	int                fails = 0;

	initial begin
		outstanding = 0;
		fail_count = 0;
	end

	task automatic collect(input logic [7:0] b);
		gathered |= 32'(b) << (8 * byte_idx[1:0]);
		byte_idx = byte_idx + 3'd1;
	endtask

	task automatic restart_item();
		byte_idx = '0;
		gathered = '0;
	endtask

	// a record is finished: back to a header once the repeats cover the loop
	task automatic close_record();
		phase = (shown >= {1'b0, loop_total}) ? lasp_pkg::PH_HEADER : lasp_pkg::PH_RECORD;
		restart_item();
	endtask

	task automatic parse_byte(input logic [7:0] b);
		lasp_pkg::result_t r;
		logic [15:0]       reps;
		logic [16:0]       hold;
		r = '0;
		case (phase)
			lasp_pkg::PH_RECORD: begin
				if (byte_idx < 3'd3) begin
					collect(b);
				end else begin
					reps = {b, gathered[23:16]};
					hold = (reps == 16'd0) ? 17'h10000 : {1'b0, reps};
					shown = shown + hold;
					r.kind = lasp_pkg::KIND_FRAME;
					r.pixel_count = gathered[15:0];
					r.hold_frames = hold;
					due_results.push_back(r);
					if (gathered[15:0] != 16'd0) begin
						pixels_left = gathered[15:0];
						phase = lasp_pkg::PH_PIXEL;
						restart_item();
					end else begin
						pixels_left = '0;
						close_record();
					end
				end
			end
			lasp_pkg::PH_PIXEL: begin
				if (byte_idx < 3'd4) begin
					collect(b);
				end else begin
					r.kind = lasp_pkg::KIND_PIXEL;
					r.pos_x = gathered[7:0];
					r.pos_y = gathered[15:8];
					r.red = gathered[23:16];
					r.green = gathered[31:24];
					r.blue = b;
					due_results.push_back(r);
					pixels_left = pixels_left - 16'd1;
					if (pixels_left == 16'd0)
						close_record();
					else
						restart_item();
				end
			end
			default: begin
				// header, and the unused phase code taken as header
				if (byte_idx < 3'd3) begin
					phase = lasp_pkg::PH_HEADER;
					collect(b);
				end else begin
					loop_total = {b, gathered[23:16]};
					shown = '0;
					pixels_left = '0;
					r.kind = lasp_pkg::KIND_HEADER;
					r.mode = gathered[7:0];
					r.fps = gathered[15:8];
					r.frame_total = loop_total;
					due_results.push_back(r);
					phase = (loop_total == 16'd0) ? lasp_pkg::PH_HEADER : lasp_pkg::PH_RECORD;
					restart_item();
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [16:0] want,
			input logic [16:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, actual %0h", name, want, seen);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		lasp_pkg::result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				parse_byte(stream_byte);
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result beat with nothing predicted, kind %0d", kind);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", 17'(want.kind), 17'(kind));
					check_field("mode", 17'(want.mode), 17'(mode));
					check_field("fps", 17'(want.fps), 17'(fps));
					check_field("frame_total", 17'(want.frame_total), 17'(frame_total));
					check_field("pixel_count", 17'(want.pixel_count), 17'(pixel_count));
					check_field("hold_frames", want.hold_frames, hold_frames);
					check_field("pos_x", 17'(want.pos_x), 17'(pos_x));
					check_field("pos_y", 17'(want.pos_y), 17'(pos_y));
					check_field("red", 17'(want.red), 17'(red));
					check_field("green", 17'(want.green), 17'(green));
					check_field("blue", 17'(want.blue), 17'(blue));
				end
			end
			outstanding <= due_results.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== verif/led_animation_stream_parser_top_test.sv =====
`timescale 1ns / 1ps
// led_animation_stream_parser_top_test: feeds animation files byte by byte into the parser
// with random gaps and output stalls; lasp_result_check does the checking
// depends on lasp_pkg, led_animation_stream_parser_top and lasp_result_check
module led_animation_stream_parser_top_test;

	localparam int BYTE_TARGET = 950;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  stream_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  mode;
	logic [7:0]  fps;
	logic [15:0] frame_total;
	logic [15:0] pixel_count;
	logic [16:0] hold_frames;
	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	int          outstanding;
	int          fail_count;
	int          cycles = 0;
	int          sent = 0;
	int          idle_pct = 28;
	int          stall_pct = 52;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	led_animation_stream_parser_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .stream_byte(stream_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .mode(mode), .fps(fps), .frame_total(frame_total),
		.pixel_count(pixel_count), .hold_frames(hold_frames),
		.pos_x(pos_x), .pos_y(pos_y), .red(red), .green(green), .blue(blue)
	);

	lasp_result_check results_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .stream_byte(stream_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .mode(mode), .fps(fps), .frame_total(frame_total),
		.pixel_count(pixel_count), .hold_frames(hold_frames),
		.pos_x(pos_x), .pos_y(pos_y), .red(red), .green(green), .blue(blue),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$error("run stalled with %0d results still due", outstanding);
			$display("led_animation_stream_parser_top_test: errors");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		logic taken;
		// few sender gaps and many output stalls first, then swapped, then none
		if (sent < BYTE_TARGET / 3) begin
			idle_pct = 28;
			stall_pct = 52;
		end else if (sent < 2 * BYTE_TARGET / 3) begin
			idle_pct = 52;
			stall_pct = 28;
		end else begin
			idle_pct = 0;
			stall_pct = 0;
		end
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		// stall is settled by the falling edge since all inputs move on the rising one
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic send_header(input logic [7:0] m, input logic [7:0] f,
			input logic [15:0] total);
		send_byte(m);
		send_byte(f);
		send_byte(total[7:0]);
		send_byte(total[15:8]);
	endtask

	task automatic send_record(input logic [15:0] cnt, input logic [15:0] rep);
		send_byte(cnt[7:0]);
		send_byte(cnt[15:8]);
		send_byte(rep[7:0]);
		send_byte(rep[15:8]);
	endtask

	// one whole file: a header, then records until the repeats cover the loop
	task automatic send_file();
		logic [15:0] total;
		logic [16:0] covered;
		logic [15:0] cnt;
		logic [15:0] rep;
		int          pick;
		pick = $urandom_range(11);
		if (pick < 2)
			total = '0;
		else if (pick < 5)
			total = 16'($urandom);
		else
			total = 16'($urandom_range(10, 1));
		send_header(8'($urandom), 8'($urandom), total);
		covered = '0;
		while (covered < {1'b0, total}) begin
			pick = $urandom_range(15);
			if (pick < 4)
				cnt = '0;
			else if (pick < 13)
				cnt = 16'($urandom_range(3, 1));
			else if (pick < 15)
				cnt = 16'($urandom_range(12, 4));
			else
				cnt = 16'($urandom_range(40, 13));
			rep = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6, 1));
			send_record(cnt, rep);
			repeat (cnt) repeat (5) send_byte(8'($urandom));
			covered = covered + ((rep == 16'd0) ? 17'h10000 : {1'b0, rep});
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// zero frame total: straight back to a header
		send_header(8'hff, 8'h00, 16'h0000);
		send_header(8'h00, 8'hff, 16'hffff);
		// one pixel, total one short of the loop
		send_record(16'h0001, 16'hfffe);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(8'hff);
		// empty record, stored repeat zero overshoots the loop
		send_record(16'h0000, 16'h0000);

		while (sent < BYTE_TARGET)
			send_file();

		in_valid <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("led_animation_stream_parser_top_test: clean");
		else
			$display("led_animation_stream_parser_top_test: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lasp_pkg.sv
rtl/lasp_parse.sv
rtl/led_animation_stream_parser_top.sv
verif/lasp_result_check.sv
verif/led_animation_stream_parser_top_test.sv
